// ===== src/dhjt_pkg.sv =====
package dhjt_pkg;

   // CORDIC iteration count (8..24)
   localparam int CordicSteps = 16;
   localparam int StepW = $clog2(CordicSteps + 1);

   // register indexes
   localparam logic [2:0] RegLinkLength    = 3'd0;
   localparam logic [2:0] RegLinkTwist     = 3'd1;
   localparam logic [2:0] RegLinkOffset    = 3'd2;
   localparam logic [2:0] RegAngleOffset   = 3'd3;
   localparam logic [2:0] RegLowerLimit    = 3'd4;
   localparam logic [2:0] RegUpperLimit    = 3'd5;
   localparam logic [2:0] RegCouplingRatio = 3'd6;
   localparam logic [2:0] RegCoupledMode   = 3'd7;

   localparam logic CmdSet = 1'b0;
   localparam logic CmdAdd = 1'b1;

   // CORDIC start value, Q2.30
   localparam logic signed [33:0] CordicX0 = 34'sd652032874;

   // arctangent table, turn units scaled by 2^32
   function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
      logic signed [33:0] r;
      begin
         case (i)
            5'd0:  r = 34'sh020000000;
            5'd1:  r = 34'sh012E4051E;
            5'd2:  r = 34'sh009FB385B;
            5'd3:  r = 34'sh0051111D4;
            5'd4:  r = 34'sh0028B0D43;
            5'd5:  r = 34'sh00145D7E1;
            5'd6:  r = 34'sh000A2F61E;
            5'd7:  r = 34'sh000517C55;
            5'd8:  r = 34'sh00028BE53;
            5'd9:  r = 34'sh000145F2F;
            5'd10: r = 34'sh0000A2F98;
            5'd11: r = 34'sh0000517CC;
            5'd12: r = 34'sh000028BE6;
            5'd13: r = 34'sh0000145F3;
            5'd14: r = 34'sh00000A2FA;
            5'd15: r = 34'sh00000517D;
            5'd16: r = 34'sh0000028BE;
            5'd17: r = 34'sh00000145F;
            5'd18: r = 34'sh000000A30;
            5'd19: r = 34'sh000000518;
            5'd20: r = 34'sh00000028C;
            5'd21: r = 34'sh000000146;
            5'd22: r = 34'sh0000000A3;
            5'd23: r = 34'sh000000051;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   typedef struct packed {
      logic        command;
      logic [15:0] angle_value;
   } req_type;

   typedef struct packed {
      logic [15:0] rot_00;
      logic [15:0] rot_10;
      logic [15:0] rot_01;
      logic [15:0] rot_11;
      logic [15:0] rot_21;
      logic [15:0] rot_02;
      logic [15:0] rot_12;
      logic [15:0] rot_22;
      logic [23:0] trans_x;
      logic [23:0] trans_y;
      logic [23:0] trans_z;
      logic [15:0] joint_angle;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  index;
      logic [23:0] data;
   } csr_type;

endpackage

// ===== src/dhjt_if.sv =====
interface dhjt_req_if;
   logic             valid;
   logic             ready;
   dhjt_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface dhjt_rsp_if;
   logic             valid;
   logic             ready;
   dhjt_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface dhjt_csr_if;
   logic             valid;
   logic             ready;
   dhjt_pkg::csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/dh_joint_transform_unit.sv =====
// DH joint transform for one revolute joint. Each request transaction
// updates the stored joint angle (set/add with clamp, or coupled gear
// ratio) and returns eleven DH matrix entries plus the stored angle.
// For each request a shared CORDIC unit runs twice, then a 16x24
// multiplier serves the products one per cycle. A new request is taken
// only while the unit is idle and the output register is empty or
// being read. Configuration writes are taken at any time, one per cycle.
module dh_joint_transform_unit (
   input  logic clock,
   input  logic reset,
   dhjt_req_if.sink   req,
   dhjt_rsp_if.source rsp,
   dhjt_csr_if.sink   csr
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_MULT  = 6'b000010,
      S_CLAMP = 6'b000100,
      S_CORD  = 6'b001000,
      S_PROD  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic signed [23:0] link_length_ff, link_offset_ff;
   logic signed [15:0] link_twist_ff, angle_offset_ff, lower_ff, upper_ff, ratio_ff;
   logic               coupled_ff;
   logic signed [15:0] stored_ff, stored_in;

   logic               cmd_ff;
   logic signed [15:0] val_ff;
   logic signed [31:0] cprod_ff;

   // CORDIC state
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic [dhjt_pkg::StepW-1:0] step_ff;
   logic               pass_ff;   // 0 joint angle, 1 twist
   logic               flip_ff;
   logic signed [15:0] cq_ff, sq_ff, ca_ff, sa_ff;

   // product sequencer
   logic [2:0]         pidx_ff;
   logic signed [39:0] pprod_ff;
   logic               pvalid_ff;
   logic [2:0]         pidx_d_ff;

   dhjt_pkg::rsp_type  out_ff;
   logic               out_valid_ff;

   // configuration port is always ready
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         link_length_ff  <= '0;
         link_twist_ff   <= '0;
         link_offset_ff  <= '0;
         angle_offset_ff <= '0;
         lower_ff        <= '0;
         upper_ff        <= '0;
         ratio_ff        <= '0;
         coupled_ff      <= 1'b0;
      end else if (csr.valid) begin
         case (csr.payload.index)
            dhjt_pkg::RegLinkLength:    link_length_ff  <= csr.payload.data;
            dhjt_pkg::RegLinkTwist:     link_twist_ff   <= csr.payload.data[15:0];
            dhjt_pkg::RegLinkOffset:    link_offset_ff  <= csr.payload.data;
            dhjt_pkg::RegAngleOffset:   angle_offset_ff <= csr.payload.data[15:0];
            dhjt_pkg::RegLowerLimit:    lower_ff        <= csr.payload.data[15:0];
            dhjt_pkg::RegUpperLimit:    upper_ff        <= csr.payload.data[15:0];
            dhjt_pkg::RegCouplingRatio: ratio_ff        <= csr.payload.data[15:0];
            dhjt_pkg::RegCoupledMode:   coupled_ff      <= csr.payload.data[0];
            default: ;
         endcase
      end
   end

   assign req.ready = (state_ff == S_IDLE) && !(out_valid_ff && !rsp.ready);

   // angle update
   logic signed [16:0] sum;
   logic signed [32:0] cround;
   always_comb begin
      sum = (cmd_ff == dhjt_pkg::CmdAdd) ? (17'(stored_ff) + 17'(val_ff)) : 17'(val_ff);
      cround = 33'(cprod_ff) + 33'sd2048;
      stored_in = stored_ff;
      if (coupled_ff) stored_in = cround[27:12];
      else if (sum > 17'(upper_ff)) stored_in = upper_ff;
      else if (sum < 17'(lower_ff)) stored_in = lower_ff;
      else stored_in = sum[15:0];
   end

   // CORDIC fold and one iteration
   logic [15:0] pass_ang, fold_ang;
   logic        fold;
   logic signed [33:0] sx, sy, nx, ny, nz, atn;
   logic [4:0]  sidx;
   always_comb begin
      pass_ang = (state_ff == S_CLAMP) ? 16'(angle_offset_ff + stored_in)
                                       : link_twist_ff;
      fold     = (pass_ang >= 16'd16384) && (pass_ang < 16'd49152);
      fold_ang = fold ? (pass_ang + 16'd32768) : pass_ang;
      sidx = 5'(step_ff);
      sx   = cx_ff >>> sidx;
      sy   = cy_ff >>> sidx;
      atn  = dhjt_pkg::atan_entry(sidx);
      if (!cz_ff[33]) begin
         nx = cx_ff - sy; ny = cy_ff + sx; nz = cz_ff - atn;
      end else begin
         nx = cx_ff + sy; ny = cy_ff - sx; nz = cz_ff + atn;
      end
   end

   // round Q2.30 to Q1.14 with saturation, negated when f is set
   function automatic logic signed [15:0] rsat(input logic signed [33:0] v, input logic f);
      logic signed [33:0] t;
      logic signed [17:0] r;
      begin
         t = (v + 34'sd32768) >>> 16;
         r = t[17:0];
         if (r > 18'sd16384) r = 18'sd16384;
         else if (r < -18'sd16384) r = -18'sd16384;
         if (f) r = -r;
         return r[15:0];
      end
   endfunction

   // product operand select
   logic signed [23:0] ma;
   logic signed [15:0] mb;
   always_comb begin
      case (pidx_ff)
         3'd0: begin ma = 24'(sq_ff); mb = ca_ff; end
         3'd1: begin ma = 24'(cq_ff); mb = ca_ff; end
         3'd2: begin ma = 24'(sq_ff); mb = sa_ff; end
         3'd3: begin ma = 24'(cq_ff); mb = sa_ff; end
         3'd4: begin ma = link_length_ff; mb = cq_ff; end
         3'd5: begin ma = link_length_ff; mb = sq_ff; end
         default: begin ma = '0; mb = '0; end
      endcase
   end

   logic signed [39:0] pr;
   logic signed [25:0] pq;
   always_comb begin
      pr = (pprod_ff + 40'sd8192) >>> 14;
      pq = pr[25:0];
      if (pq > 26'sd8388607) pq = 26'sd8388607;
      else if (pq < -26'sd8388608) pq = -26'sd8388608;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req.valid && req.ready) state_in = S_MULT;
         S_MULT:  state_in = S_CLAMP;
         S_CLAMP: state_in = S_CORD;
         S_CORD:  if (pass_ff && step_ff == dhjt_pkg::StepW'(dhjt_pkg::CordicSteps))
                     state_in = S_PROD;
         S_PROD:  if (pvalid_ff && pidx_d_ff == 3'd5) state_in = S_DONE;
         S_DONE:  if (!out_valid_ff || rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stored_ff    <= '0;
         out_valid_ff <= 1'b0;
         pvalid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_DONE && (!out_valid_ff || rsp.ready)) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
         if (state_ff == S_CLAMP) stored_ff <= stored_in;
         pvalid_ff <= (state_ff == S_PROD) && (pidx_ff < 3'd6);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            cmd_ff <= req.payload.command;
            val_ff <= req.payload.angle_value;
            pass_ff <= 1'b0;
         end
         S_MULT: cprod_ff <= ratio_ff * val_ff;
         S_CLAMP: begin
            // load first rotation with the angle offset plus the updated joint angle
            cx_ff   <= dhjt_pkg::CordicX0;
            cy_ff   <= '0;
            cz_ff   <= 34'(signed'(fold_ang)) <<< 16;
            flip_ff <= fold;
            step_ff <= '0;
         end
         S_CORD: begin
            if (step_ff == dhjt_pkg::StepW'(dhjt_pkg::CordicSteps)) begin
               if (!pass_ff) begin
                  cq_ff   <= rsat(cx_ff, flip_ff);
                  sq_ff   <= rsat(cy_ff, flip_ff);
                  pass_ff <= 1'b1;
                  cx_ff   <= dhjt_pkg::CordicX0;
                  cy_ff   <= '0;
                  cz_ff   <= 34'(signed'(fold_ang)) <<< 16;
                  flip_ff <= fold;
                  step_ff <= '0;
               end else begin
                  ca_ff   <= rsat(cx_ff, flip_ff);
                  sa_ff   <= rsat(cy_ff, flip_ff);
                  pidx_ff <= '0;
               end
            end else begin
               cx_ff   <= nx;
               cy_ff   <= ny;
               cz_ff   <= nz;
               step_ff <= step_ff + 1'b1;
            end
         end
         S_PROD: begin
            pprod_ff  <= ma * mb;
            pidx_d_ff <= pidx_ff;
            if (pidx_ff < 3'd6) pidx_ff <= pidx_ff + 1'b1;
            if (pvalid_ff) begin
               case (pidx_d_ff)
                  3'd0: out_ff.rot_01  <= -pq[15:0];
                  3'd1: out_ff.rot_11  <= pq[15:0];
                  3'd2: out_ff.rot_02  <= pq[15:0];
                  3'd3: out_ff.rot_12  <= -pq[15:0];
                  3'd4: out_ff.trans_x <= pq[23:0];
                  3'd5: out_ff.trans_y <= pq[23:0];
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      if (state_ff == S_DONE && (!out_valid_ff || rsp.ready)) begin
         out_ff.rot_00      <= cq_ff;
         out_ff.rot_10      <= sq_ff;
         out_ff.rot_21      <= sa_ff;
         out_ff.rot_22      <= ca_ff;
         out_ff.trans_z     <= link_offset_ff;
         out_ff.joint_angle <= stored_ff;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

endmodule

// ===== bench/tb_dhjt_if.sv =====
`timescale 1ns / 1ps

// Bench-side copies of the channel interfaces are not needed: the RTL
// interfaces are used directly. This file holds a small driver-side
// interface for the receiver hold-off control.
interface tb_hold_if;
   logic hold;
endinterface

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dhjt_req_if req_ch ();
   dhjt_rsp_if rsp_ch ();
   dhjt_csr_if csr_ch ();
   tb_hold_if  hold_ch ();

   dh_joint_transform_unit u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the configuration and joint state
   logic [23:0] sh_length, sh_offset_d;
   logic [15:0] sh_twist, sh_theta, sh_lower, sh_upper, sh_ratio, sh_angle;
   logic        sh_coupled;

   dhjt_pkg::rsp_type expected_q[$];
   int          error_count = 0;
   int          sent_count = 0;
   int          got_count = 0;
   int          cycle_count = 0;
   int          hold_cycles = 0;
   logic        rx_mute = 1'b0;

   localparam int CycleLimit = 900000;

   // atan table in turn units scaled by 2^32
   function automatic longint atan_val(input int i);
      longint t [24] = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
         64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53,
         64'h00145F2F, 64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3,
         64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30,
         64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
      return t[i];
   endfunction

   // sine and cosine of a binary angle, Q1.14
   task automatic cordic_sincos(input logic [15:0] ang, output longint c,
                                output longint s);
      logic [15:0] u;
      logic        flip;
      longint      x, y, z, nx;
      u = ang;
      flip = 1'b0;
      x = 652032874;
      y = 0;
      if (u >= 16'd16384 && u < 16'd49152) begin
         u = u + 16'd32768;
         flip = 1'b1;
      end
      z = longint'($signed(u)) * 65536;
      for (int i = 0; i < dhjt_pkg::CordicSteps && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - atan_val(i);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + atan_val(i);
         end
         x = nx;
      end
      x = (x + 32768) >>> 16;
      y = (y + 32768) >>> 16;
      if (x > 16384) x = 16384;
      if (x < -16384) x = -16384;
      if (y > 16384) y = 16384;
      if (y < -16384) y = -16384;
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic longint q14_mul(input longint a, input longint b);
      return (a * b + 8192) >>> 14;
   endfunction

   function automatic longint sat24(input longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   // advance the joint state and queue the matrix it gives
   task automatic predict_transform(input dhjt_pkg::req_type item);
      longint  v, t, cq, sq, ca, sa, a;
      dhjt_pkg::rsp_type r;
      v = longint'($signed(item.angle_value));
      if (sh_coupled) begin
         t = (longint'($signed(sh_ratio)) * v + 2048) >>> 12;
      end else begin
         t = (item.command == dhjt_pkg::CmdAdd) ? longint'($signed(sh_angle)) + v : v;
         if (t > longint'($signed(sh_upper))) t = longint'($signed(sh_upper));
         else if (t < longint'($signed(sh_lower))) t = longint'($signed(sh_lower));
      end
      sh_angle = t[15:0];
      cordic_sincos(sh_theta + sh_angle, cq, sq);
      cordic_sincos(sh_twist, ca, sa);
      a = longint'($signed(sh_length));
      r.rot_00 = cq[15:0];
      r.rot_10 = sq[15:0];
      r.rot_01 = 16'(-q14_mul(sq, ca));
      r.rot_11 = 16'(q14_mul(cq, ca));
      r.rot_21 = sa[15:0];
      r.rot_02 = 16'(q14_mul(sq, sa));
      r.rot_12 = 16'(-q14_mul(cq, sa));
      r.rot_22 = ca[15:0];
      r.trans_x = 24'(sat24(q14_mul(a, cq)));
      r.trans_y = 24'(sat24(q14_mul(a, sq)));
      r.trans_z = sh_offset_d;
      r.joint_angle = sh_angle;
      expected_q = {expected_q, r};
   endtask

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      $display("mismatch at transaction %0d: %s got %h expected %h",
               got_count, what, got, want);
      error_count++;
   endtask

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // drive inputs to known values
   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_ch.valid = 1'b0;
      csr_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      hold_ch.hold = 1'b0;
   end

   // result receiver with random stalls and long hold-off
   initial begin
      int g;
      @(negedge clock);
      forever begin
         if (hold_ch.hold) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles = 0;
            while (hold_cycles < 400) begin
               @(negedge clock);
               hold_cycles++;
            end
            hold_ch.hold = 1'b0;
         end
         g = rx_mute ? 0 : gap_len();
         if (g > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(negedge clock);
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      dhjt_pkg::rsp_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result", got.joint_angle, 0);
         end else begin
            want = expected_q.pop_front();
            if (got.rot_00 !== want.rot_00) report_mismatch("rot_00", got.rot_00, want.rot_00);
            if (got.rot_10 !== want.rot_10) report_mismatch("rot_10", got.rot_10, want.rot_10);
            if (got.rot_01 !== want.rot_01) report_mismatch("rot_01", got.rot_01, want.rot_01);
            if (got.rot_11 !== want.rot_11) report_mismatch("rot_11", got.rot_11, want.rot_11);
            if (got.rot_21 !== want.rot_21) report_mismatch("rot_21", got.rot_21, want.rot_21);
            if (got.rot_02 !== want.rot_02) report_mismatch("rot_02", got.rot_02, want.rot_02);
            if (got.rot_12 !== want.rot_12) report_mismatch("rot_12", got.rot_12, want.rot_12);
            if (got.rot_22 !== want.rot_22) report_mismatch("rot_22", got.rot_22, want.rot_22);
            if (got.trans_x !== want.trans_x)
               report_mismatch("trans_x", got.trans_x, want.trans_x);
            if (got.trans_y !== want.trans_y)
               report_mismatch("trans_y", got.trans_y, want.trans_y);
            if (got.trans_z !== want.trans_z)
               report_mismatch("trans_z", got.trans_z, want.trans_z);
            if (got.joint_angle !== want.joint_angle)
               report_mismatch("joint_angle", got.joint_angle, want.joint_angle);
         end
         got_count++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // one request transaction, with an optional random gap first
   task automatic send_command(input logic cmd, input logic [15:0] value,
                               input bit gaps);
      dhjt_pkg::req_type item;
      int      g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      item.command = cmd;
      item.angle_value = value;
      req_ch.payload <= item;
      req_ch.valid <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_transform(item);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
      dhjt_pkg::csr_type w;
      w.index = idx;
      w.data = value;
      csr_ch.payload <= w;
      csr_ch.valid <= 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         dhjt_pkg::RegLinkLength:    sh_length = value;
         dhjt_pkg::RegLinkTwist:     sh_twist = value[15:0];
         dhjt_pkg::RegLinkOffset:    sh_offset_d = value;
         dhjt_pkg::RegAngleOffset:   sh_theta = value[15:0];
         dhjt_pkg::RegLowerLimit:    sh_lower = value[15:0];
         dhjt_pkg::RegUpperLimit:    sh_upper = value[15:0];
         dhjt_pkg::RegCouplingRatio: sh_ratio = value[15:0];
         dhjt_pkg::RegCoupledMode:   sh_coupled = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // wait until every result is back, then let the pipe settle
   task automatic drain();
      end_burst();
      while (expected_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_geometry(input logic [23:0] len, input logic [15:0] twist,
                                 input logic [23:0] d, input logic [15:0] theta);
      write_reg(dhjt_pkg::RegLinkLength, len);
      write_reg(dhjt_pkg::RegLinkTwist, 24'(twist));
      write_reg(dhjt_pkg::RegLinkOffset, d);
      write_reg(dhjt_pkg::RegAngleOffset, 24'(theta));
   endtask

   task automatic write_joint(input logic [15:0] lo, input logic [15:0] hi,
                              input logic [15:0] ratio, input logic mode);
      write_reg(dhjt_pkg::RegLowerLimit, 24'(lo));
      write_reg(dhjt_pkg::RegUpperLimit, 24'(hi));
      write_reg(dhjt_pkg::RegCouplingRatio, 24'(ratio));
      write_reg(dhjt_pkg::RegCoupledMode, 24'(mode));
   endtask

   // reset values, then set/add at field extremes with full limits
   task automatic test_driven_extremes();
      send_command(dhjt_pkg::CmdSet, 16'h1234, 1'b0);
      drain();
      write_geometry(24'h7FFFFF, 16'h2000, 24'h800000, 16'h0000);
      write_joint(16'h8000, 16'h7FFF, 16'h1000, 1'b0);
      send_command(dhjt_pkg::CmdSet, 16'h7FFF, 1'b0);
      send_command(dhjt_pkg::CmdAdd, 16'h7FFF, 1'b0);
      send_command(dhjt_pkg::CmdSet, 16'h8000, 1'b0);
      send_command(dhjt_pkg::CmdAdd, 16'h8000, 1'b0);
      send_command(dhjt_pkg::CmdSet, 16'h4000, 1'b0);
      send_command(dhjt_pkg::CmdSet, 16'hC000, 1'b0);
      send_command(dhjt_pkg::CmdSet, 16'h0000, 1'b0);
      send_command(dhjt_pkg::CmdAdd, 16'hFFFF, 1'b0);
      drain();
   endtask

   // translation saturation: a = -2^23 with cos q = -1
   task automatic test_translation_saturation();
      write_geometry(24'h800000, 16'h0000, 24'h7FFFFF, 16'h8000);
      send_command(dhjt_pkg::CmdSet, 16'h0000, 1'b0);
      drain();
      write_reg(dhjt_pkg::RegAngleOffset, 24'h000000);
      send_command(dhjt_pkg::CmdSet, 16'hC000, 1'b0);
      drain();
   endtask

   // narrow and inverted limits
   task automatic test_limits();
      write_joint(16'hF000, 16'h1000, 16'h0000, 1'b0);
      send_command(dhjt_pkg::CmdSet, 16'h2000, 1'b0);
      send_command(dhjt_pkg::CmdSet, 16'hE000, 1'b0);
      send_command(dhjt_pkg::CmdAdd, 16'h0800, 1'b0);
      drain();
      write_joint(16'h1000, 16'hF000, 16'h0000, 1'b0);
      send_command(dhjt_pkg::CmdSet, 16'h0000, 1'b0);
      send_command(dhjt_pkg::CmdSet, 16'hE000, 1'b0);
      send_command(dhjt_pkg::CmdAdd, 16'h0001, 1'b0);
      drain();
   endtask

   // coupled mode with extreme ratios, wraparound of the product
   task automatic test_coupled();
      write_joint(16'h0000, 16'h0000, 16'h7FFF, 1'b1);
      send_command(dhjt_pkg::CmdSet, 16'h7FFF, 1'b0);
      send_command(dhjt_pkg::CmdAdd, 16'h8000, 1'b0);
      drain();
      write_reg(dhjt_pkg::RegCouplingRatio, 24'h008000);
      send_command(dhjt_pkg::CmdSet, 16'h8000, 1'b0);
      send_command(dhjt_pkg::CmdAdd, 16'h0001, 1'b0);
      send_command(dhjt_pkg::CmdSet, 16'h0800, 1'b0);
      drain();
   endtask

   // random traffic over several register settings
   task automatic test_random(input int phases, input int per_phase);
      for (int p = 0; p < phases; p++) begin
         write_geometry(24'($urandom), 16'($urandom), 24'($urandom), 16'($urandom));
         write_joint(16'($urandom), 16'($urandom), 16'($urandom),
                     ($urandom_range(0, 3) == 0));
         for (int k = 0; k < per_phase; k++)
            send_command(1'($urandom), 16'($urandom), 1'b1);
         drain();
      end
   endtask

   // receiver stalls long while requests keep coming
   task automatic test_backpressure();
      write_joint(16'h8000, 16'h7FFF, 16'h0C00, 1'b0);
      hold_ch.hold = 1'b1;
      for (int k = 0; k < 20; k++)
         send_command(1'($urandom), 16'($urandom), 1'b0);
      drain();
   endtask

   // back-to-back traffic, no receiver gaps
   task automatic test_streaming();
      rx_mute = 1'b1;
      for (int k = 0; k < 40; k++)
         send_command(1'($urandom), 16'($urandom), 1'b0);
      drain();
      rx_mute = 1'b0;
   endtask

   initial begin
      sh_length = '0; sh_offset_d = '0; sh_twist = '0; sh_theta = '0;
      sh_lower = '0; sh_upper = '0; sh_ratio = '0; sh_angle = '0;
      sh_coupled = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      test_driven_extremes();
      test_translation_saturation();
      test_limits();
      test_coupled();
      test_backpressure();
      test_streaming();
      test_random(20, 50);
      $display("covered %0d request transactions, %0d results checked", sent_count,
               got_count);
      $display("driven and coupled modes, limits, saturation and stalls exercised");
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("errors: %0d, missing results: %0d", error_count, expected_q.size());
         $display("simulation failed");
      end
      $finish;
   end

endmodule
